// ===== design/segint_pkg.sv =====
// shared types and constants for the segment intersection test
package segint_pkg;

	localparam int unsigned NUM_AREAS = 4;

	// slot of each triangle area, also used for the matching endpoint test
	localparam int unsigned IDX_ABC = 0;
	localparam int unsigned IDX_ABD = 1;
	localparam int unsigned IDX_CDA = 2;
	localparam int unsigned IDX_CDB = 3;

	// per area: endpoint falls within the span of the other segment
	typedef logic [NUM_AREAS-1:0] segint_span_t;

	typedef struct packed {
		logic [NUM_AREAS-1:0] zero;
		logic [NUM_AREAS-1:0] pos;
	} segint_flags_t;

endpackage

// ===== design/segint_diff.sv =====
// stage one: coordinate differences and endpoint span tests
module segint_diff import segint_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	localparam int DW = COORD_WIDTH + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by,
	input  logic signed [COORD_WIDTH-1:0] cx,
	input  logic signed [COORD_WIDTH-1:0] cy,
	input  logic signed [COORD_WIDTH-1:0] dx,
	input  logic signed [COORD_WIDTH-1:0] dy,
	output logic                          vld_s1,
	output logic signed [DW-1:0]          bax_s1,
	output logic signed [DW-1:0]          bay_s1,
	output logic signed [DW-1:0]          cax_s1,
	output logic signed [DW-1:0]          cay_s1,
	output logic signed [DW-1:0]          dax_s1,
	output logic signed [DW-1:0]          day_s1,
	output logic signed [DW-1:0]          dcx_s1,
	output logic signed [DW-1:0]          dcy_s1,
	output logic signed [DW-1:0]          acx_s1,
	output logic signed [DW-1:0]          acy_s1,
	output logic signed [DW-1:0]          bcx_s1,
	output logic signed [DW-1:0]          bcy_s1,
	output segint_span_t                  span_s1
);

	function automatic logic signed [DW-1:0] sub(
		input logic signed [COORD_WIDTH-1:0] p,
		input logic signed [COORD_WIDTH-1:0] q
	);
		logic signed [DW-1:0] pe;
		logic signed [DW-1:0] qe;
		pe = DW'(p);
		qe = DW'(q);
		return pe - qe;
	endfunction

	function automatic logic between(
		input logic signed [COORD_WIDTH-1:0] lo,
		input logic signed [COORD_WIDTH-1:0] hi,
		input logic signed [COORD_WIDTH-1:0] v
	);
		return ((lo <= v) && (v <= hi)) || ((hi <= v) && (v <= lo));
	endfunction

	// range part of point p on segment qr, collinearity checked later
	function automatic logic span(
		input logic signed [COORD_WIDTH-1:0] qx,
		input logic signed [COORD_WIDTH-1:0] qy,
		input logic signed [COORD_WIDTH-1:0] rx,
		input logic signed [COORD_WIDTH-1:0] ry,
		input logic signed [COORD_WIDTH-1:0] px,
		input logic signed [COORD_WIDTH-1:0] py
	);
		logic r;
		if (qx != rx) begin
			r = between(qx, rx, px);
		end else if (qy != ry) begin
			r = between(qy, ry, py);
		end else begin
			r = (px == qx) && (py == qy);
		end
		return r;
	endfunction

	segint_span_t span_d;

	always_comb begin
		span_d          = '0;
		span_d[IDX_ABC] = span(ax, ay, bx, by, cx, cy);
		span_d[IDX_ABD] = span(ax, ay, bx, by, dx, dy);
		span_d[IDX_CDA] = span(cx, cy, dx, dy, ax, ay);
		span_d[IDX_CDB] = span(cx, cy, dx, dy, bx, by);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bax_s1  <= sub(bx, ax);
			bay_s1  <= sub(by, ay);
			cax_s1  <= sub(cx, ax);
			cay_s1  <= sub(cy, ay);
			dax_s1  <= sub(dx, ax);
			day_s1  <= sub(dy, ay);
			dcx_s1  <= sub(dx, cx);
			dcy_s1  <= sub(dy, cy);
			acx_s1  <= sub(ax, cx);
			acy_s1  <= sub(ay, cy);
			bcx_s1  <= sub(bx, cx);
			bcy_s1  <= sub(by, cy);
			span_s1 <= span_d;
		end
	end

endmodule

// ===== design/segint_mul.sv =====
// stage two: the eight cross product terms
module segint_mul import segint_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	localparam int DW = COORD_WIDTH + 1,
	localparam int PW = 2 * DW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_s1,
	input  logic signed [DW-1:0] bax_s1,
	input  logic signed [DW-1:0] bay_s1,
	input  logic signed [DW-1:0] cax_s1,
	input  logic signed [DW-1:0] cay_s1,
	input  logic signed [DW-1:0] dax_s1,
	input  logic signed [DW-1:0] day_s1,
	input  logic signed [DW-1:0] dcx_s1,
	input  logic signed [DW-1:0] dcy_s1,
	input  logic signed [DW-1:0] acx_s1,
	input  logic signed [DW-1:0] acy_s1,
	input  logic signed [DW-1:0] bcx_s1,
	input  logic signed [DW-1:0] bcy_s1,
	input  segint_span_t         span_s1,
	output logic                 vld_s2,
	output logic signed [PW-1:0] p_abc0_s2,
	output logic signed [PW-1:0] p_abc1_s2,
	output logic signed [PW-1:0] p_abd0_s2,
	output logic signed [PW-1:0] p_abd1_s2,
	output logic signed [PW-1:0] p_cda0_s2,
	output logic signed [PW-1:0] p_cda1_s2,
	output logic signed [PW-1:0] p_cdb0_s2,
	output logic signed [PW-1:0] p_cdb1_s2,
	output segint_span_t         span_s2
);

	function automatic logic signed [PW-1:0] mul(
		input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b
	);
		logic signed [PW-1:0] ae;
		logic signed [PW-1:0] be;
		ae = PW'(a);
		be = PW'(b);
		return ae * be;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_abc0_s2 <= mul(bax_s1, cay_s1);
			p_abc1_s2 <= mul(cax_s1, bay_s1);
			p_abd0_s2 <= mul(bax_s1, day_s1);
			p_abd1_s2 <= mul(dax_s1, bay_s1);
			p_cda0_s2 <= mul(dcx_s1, acy_s1);
			p_cda1_s2 <= mul(acx_s1, dcy_s1);
			p_cdb0_s2 <= mul(dcx_s1, bcy_s1);
			p_cdb1_s2 <= mul(bcx_s1, dcy_s1);
			span_s2   <= span_s1;
		end
	end

endmodule

// ===== design/segint_area.sv =====
// stage three: triangle areas reduced to zero and sign flags
module segint_area import segint_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	localparam int PW = 2 * (COORD_WIDTH + 1),
	localparam int AW = PW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_s2,
	input  logic signed [PW-1:0] p_abc0_s2,
	input  logic signed [PW-1:0] p_abc1_s2,
	input  logic signed [PW-1:0] p_abd0_s2,
	input  logic signed [PW-1:0] p_abd1_s2,
	input  logic signed [PW-1:0] p_cda0_s2,
	input  logic signed [PW-1:0] p_cda1_s2,
	input  logic signed [PW-1:0] p_cdb0_s2,
	input  logic signed [PW-1:0] p_cdb1_s2,
	input  segint_span_t         span_s2,
	output logic                 vld_s3,
	output segint_flags_t        flags_s3,
	output segint_span_t         span_s3
);

	logic signed [AW-1:0] area [NUM_AREAS];
	segint_flags_t        flags_d;

	function automatic logic signed [AW-1:0] diff(
		input logic signed [PW-1:0] a,
		input logic signed [PW-1:0] b
	);
		logic signed [AW-1:0] ae;
		logic signed [AW-1:0] be;
		ae = AW'(a);
		be = AW'(b);
		return ae - be;
	endfunction

	always_comb begin
		area[IDX_ABC] = diff(p_abc0_s2, p_abc1_s2);
		area[IDX_ABD] = diff(p_abd0_s2, p_abd1_s2);
		area[IDX_CDA] = diff(p_cda0_s2, p_cda1_s2);
		area[IDX_CDB] = diff(p_cdb0_s2, p_cdb1_s2);
		for (int i = 0; i < NUM_AREAS; i++) begin
			flags_d.zero[i] = (area[i] == '0);
			flags_d.pos[i]  = !area[i][AW-1] && (area[i] != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s3 <= flags_d;
			span_s3  <= span_s2;
		end
	end

endmodule

// ===== design/segment_intersection_test.sv =====
// top level of the segment intersection test: four stage pipeline
// an input passes the s1, s2 and s3 registers and the output register in turn
// one pair per cycle unless stalled, set by the single shared stage enable
// a stalled output holds every stage, so the input stalls in the same cycle
// reset clears the valid bits of all stages; data registers are not reset
// no state is kept between items
module segment_intersection_test import segint_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by,
	input  logic signed [COORD_WIDTH-1:0] cx,
	input  logic signed [COORD_WIDTH-1:0] cy,
	input  logic signed [COORD_WIDTH-1:0] dx,
	input  logic signed [COORD_WIDTH-1:0] dy,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          intersects,
	output logic                          proper_crossing
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;

	logic en;

	logic                 vld_s1;
	logic signed [DW-1:0] bax_s1, bay_s1, cax_s1, cay_s1, dax_s1, day_s1;
	logic signed [DW-1:0] dcx_s1, dcy_s1, acx_s1, acy_s1, bcx_s1, bcy_s1;
	segint_span_t         span_s1;

	logic                 vld_s2;
	logic signed [PW-1:0] p_abc0_s2, p_abc1_s2, p_abd0_s2, p_abd1_s2;
	logic signed [PW-1:0] p_cda0_s2, p_cda1_s2, p_cdb0_s2, p_cdb1_s2;
	segint_span_t         span_s2;

	logic          vld_s3;
	segint_flags_t flags_s3;
	segint_span_t  span_s3;

	logic proper_d;
	logic hit_d;

	// whole pipeline moves unless a finished result is held
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	segint_diff #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (in_valid),
		.ax      (ax),
		.ay      (ay),
		.bx      (bx),
		.by      (by),
		.cx      (cx),
		.cy      (cy),
		.dx      (dx),
		.dy      (dy),
		.vld_s1  (vld_s1),
		.bax_s1  (bax_s1),
		.bay_s1  (bay_s1),
		.cax_s1  (cax_s1),
		.cay_s1  (cay_s1),
		.dax_s1  (dax_s1),
		.day_s1  (day_s1),
		.dcx_s1  (dcx_s1),
		.dcy_s1  (dcy_s1),
		.acx_s1  (acx_s1),
		.acy_s1  (acy_s1),
		.bcx_s1  (bcx_s1),
		.bcy_s1  (bcy_s1),
		.span_s1 (span_s1)
	);

	segint_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_s1    (vld_s1),
		.bax_s1    (bax_s1),
		.bay_s1    (bay_s1),
		.cax_s1    (cax_s1),
		.cay_s1    (cay_s1),
		.dax_s1    (dax_s1),
		.day_s1    (day_s1),
		.dcx_s1    (dcx_s1),
		.dcy_s1    (dcy_s1),
		.acx_s1    (acx_s1),
		.acy_s1    (acy_s1),
		.bcx_s1    (bcx_s1),
		.bcy_s1    (bcy_s1),
		.span_s1   (span_s1),
		.vld_s2    (vld_s2),
		.p_abc0_s2 (p_abc0_s2),
		.p_abc1_s2 (p_abc1_s2),
		.p_abd0_s2 (p_abd0_s2),
		.p_abd1_s2 (p_abd1_s2),
		.p_cda0_s2 (p_cda0_s2),
		.p_cda1_s2 (p_cda1_s2),
		.p_cdb0_s2 (p_cdb0_s2),
		.p_cdb1_s2 (p_cdb1_s2),
		.span_s2   (span_s2)
	);

	segint_area #(.COORD_WIDTH(COORD_WIDTH)) u_area (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_s2    (vld_s2),
		.p_abc0_s2 (p_abc0_s2),
		.p_abc1_s2 (p_abc1_s2),
		.p_abd0_s2 (p_abd0_s2),
		.p_abd1_s2 (p_abd1_s2),
		.p_cda0_s2 (p_cda0_s2),
		.p_cda1_s2 (p_cda1_s2),
		.p_cdb0_s2 (p_cdb0_s2),
		.p_cdb1_s2 (p_cdb1_s2),
		.span_s2   (span_s2),
		.vld_s3    (vld_s3),
		.flags_s3  (flags_s3),
		.span_s3   (span_s3)
	);

	// strict opposite sides on both segments, nothing collinear
	assign proper_d = !(|flags_s3.zero)
		&& (flags_s3.pos[IDX_ABC] != flags_s3.pos[IDX_ABD])
		&& (flags_s3.pos[IDX_CDA] != flags_s3.pos[IDX_CDB]);

	// endpoint on the other segment: collinear and within its span
	assign hit_d = proper_d || (|(flags_s3.zero & span_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			intersects      <= hit_d;
			proper_crossing <= proper_d;
		end
	end

endmodule

// ===== tb/segment_intersection_checker.sv =====
// checker for the segment intersection test: watches both channels, predicts and compares
module segment_intersection_checker import segint_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by,
	input  logic signed [COORD_WIDTH-1:0] cx,
	input  logic signed [COORD_WIDTH-1:0] cy,
	input  logic signed [COORD_WIDTH-1:0] dx,
	input  logic signed [COORD_WIDTH-1:0] dy,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          intersects,
	input  logic                          proper_crossing,
	output int                            mismatches,
	output int                            outstanding
);

	typedef struct packed {
		logic intersects;
		logic proper_crossing;
	} seg_verdict_t;

	seg_verdict_t expected_verdicts[$];

	function automatic longint twice_area(input longint px, input longint py, input longint qx,
		input longint qy, input longint rx, input longint ry);
		return (qx - px) * (ry - py) - (rx - px) * (qy - py);
	endfunction

	function automatic bit in_span(input longint lo, input longint hi, input longint v);
		return (lo <= v && v <= hi) || (hi <= v && v <= lo);
	endfunction

	// point p on segment qr, ends included
	function automatic bit point_on_segment(input longint qx, input longint qy, input longint rx,
		input longint ry, input longint px, input longint py);
		if (twice_area(qx, qy, rx, ry, px, py) != 0) begin
			return 1'b0;
		end
		if (qx != rx) begin
			return in_span(qx, rx, px);
		end
		if (qy != ry) begin
			return in_span(qy, ry, py);
		end
		return px == qx && py == qy;
	endfunction

	function automatic seg_verdict_t judge_pair(input longint pax, input longint pay,
		input longint pbx, input longint pby, input longint pcx, input longint pcy,
		input longint pdx, input longint pdy);
		longint       area [NUM_AREAS];
		bit           crossing;
		seg_verdict_t v;
		area[IDX_ABC] = twice_area(pax, pay, pbx, pby, pcx, pcy);
		area[IDX_ABD] = twice_area(pax, pay, pbx, pby, pdx, pdy);
		area[IDX_CDA] = twice_area(pcx, pcy, pdx, pdy, pax, pay);
		area[IDX_CDB] = twice_area(pcx, pcy, pdx, pdy, pbx, pby);
		crossing = area[IDX_ABC] != 0 && area[IDX_ABD] != 0 &&
			area[IDX_CDA] != 0 && area[IDX_CDB] != 0 &&
			((area[IDX_ABC] > 0) != (area[IDX_ABD] > 0)) &&
			((area[IDX_CDA] > 0) != (area[IDX_CDB] > 0));
		v.proper_crossing = crossing;
		v.intersects = crossing ||
			point_on_segment(pax, pay, pbx, pby, pcx, pcy) ||
			point_on_segment(pax, pay, pbx, pby, pdx, pdy) ||
			point_on_segment(pcx, pcy, pdx, pdy, pax, pay) ||
			point_on_segment(pcx, pcy, pdx, pdy, pbx, pby);
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		seg_verdict_t want;
		int           bad;
		if (!arst_n) begin
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			if (out_valid && !out_stall) begin
				if (expected_verdicts.size() == 0) begin
					$error("result with none expected: intersects %0b proper_crossing %0b",
						intersects, proper_crossing);
					bad++;
				end else begin
					want = expected_verdicts.pop_front();
					if (intersects !== want.intersects) begin
						$error("intersects: expected %0b, got %0b", want.intersects,
							intersects);
						bad++;
					end
					if (proper_crossing !== want.proper_crossing) begin
						$error("proper_crossing: expected %0b, got %0b",
							want.proper_crossing, proper_crossing);
						bad++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				expected_verdicts.push_back(judge_pair(ax, ay, bx, by, cx, cy, dx, dy));
			end
			mismatches  <= mismatches + bad;
			outstanding <= expected_verdicts.size();
		end
	end

endmodule

// ===== tb/segment_intersection_test_tb.sv =====
// testbench top for the segment intersection test: stimulus, clock, reset and verdict
module segment_intersection_test_tb;

	localparam int COORD_WIDTH = 16;
	localparam int CLK_PERIOD  = 8;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_PAIRS = 850;
	localparam int LATENCY      = 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PERCENT = 28;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid;
	logic                          in_stall;
	logic signed [COORD_WIDTH-1:0] ax;
	logic signed [COORD_WIDTH-1:0] ay;
	logic signed [COORD_WIDTH-1:0] bx;
	logic signed [COORD_WIDTH-1:0] by;
	logic signed [COORD_WIDTH-1:0] cx;
	logic signed [COORD_WIDTH-1:0] cy;
	logic signed [COORD_WIDTH-1:0] dx;
	logic signed [COORD_WIDTH-1:0] dy;
	logic                          out_valid;
	logic                          out_stall;
	logic                          intersects;
	logic                          proper_crossing;
	int                            mismatches;
	int                            outstanding;
	bit                            tx_calm;

	always #(CLK_PERIOD / 2) clk = ~clk;

	segment_intersection_test #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.ax             (ax),
		.ay             (ay),
		.bx             (bx),
		.by             (by),
		.cx             (cx),
		.cy             (cy),
		.dx             (dx),
		.dy             (dy),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.intersects     (intersects),
		.proper_crossing(proper_crossing)
	);

	segment_intersection_checker #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.ax             (ax),
		.ay             (ay),
		.bx             (bx),
		.by             (by),
		.cx             (cx),
		.cy             (cy),
		.dx             (dx),
		.dy             (dy),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.intersects     (intersects),
		.proper_crossing(proper_crossing),
		.mismatches     (mismatches),
		.outstanding    (outstanding)
	);

	function automatic int rand_signed(input int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	task automatic send_pair(input int pax, input int pay, input int pbx, input int pby,
		input int pcx, input int pcy, input int pdx, input int pdy);
		while (!tx_calm && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ax <= pax[COORD_WIDTH-1:0];
		ay <= pay[COORD_WIDTH-1:0];
		bx <= pbx[COORD_WIDTH-1:0];
		by <= pby[COORD_WIDTH-1:0];
		cx <= pcx[COORD_WIDTH-1:0];
		cy <= pcy[COORD_WIDTH-1:0];
		dx <= pdx[COORD_WIDTH-1:0];
		dy <= pdy[COORD_WIDTH-1:0];
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic send_random_pair();
		int q [8];
		int sel;
		int px;
		int py;
		int ux;
		int uy;
		int vx;
		int vy;
		int k;
		sel = $urandom_range(9);
		case (sel)
			0, 1: begin
				for (int i = 0; i < 8; i++) q[i] = int'($urandom);
			end
			2: begin
				for (int i = 0; i < 8; i++) q[i] = rand_signed(4);
			end
			3, 4, 5, 6: begin
				// points along one line (sel 5 and 6 move the last point off it), zero direction gives coincident points
				px = rand_signed(1000);
				py = rand_signed(1000);
				ux = ($urandom_range(3) == 0) ? 0 : rand_signed(6);
				uy = ($urandom_range(3) == 0) ? 0 : rand_signed(6);
				for (int i = 0; i < 4; i++) begin
					k = rand_signed(10);
					q[2*i]   = px + k * ux;
					q[2*i+1] = py + k * uy;
				end
				if (sel > 4) begin
					q[6] = px + rand_signed(60);
					q[7] = py + rand_signed(60);
				end
			end
			7, 8: begin
				px = rand_signed(1000);
				py = rand_signed(1000);
				ux = rand_signed(20);
				uy = rand_signed(20);
				vx = rand_signed(20);
				vy = rand_signed(20);
				q[0] = px - int'($urandom_range(1, 20)) * ux;
				q[1] = py - int'($urandom_range(1, 20)) * uy;
				q[2] = px + int'($urandom_range(1, 20)) * ux;
				q[3] = py + int'($urandom_range(1, 20)) * uy;
				q[4] = px - int'($urandom_range(1, 20)) * vx;
				q[5] = py - int'($urandom_range(1, 20)) * vy;
				q[6] = px + int'($urandom_range(1, 20)) * vx;
				q[7] = py + int'($urandom_range(1, 20)) * vy;
			end
			default: begin
				for (int i = 0; i < 8; i++) begin
					case ($urandom_range(6))
						0: q[i] = -32768;
						1: q[i] = -32767;
						2: q[i] = -1;
						3: q[i] = 0;
						4: q[i] = 1;
						5: q[i] = 32766;
						default: q[i] = 32767;
					endcase
				end
			end
		endcase
		// random endpoint order and segment order
		if ($urandom_range(1)) begin
			for (int i = 0; i < 2; i++) begin
				k = q[i]; q[i] = q[i+2]; q[i+2] = k;
			end
		end
		if ($urandom_range(1)) begin
			for (int i = 4; i < 6; i++) begin
				k = q[i]; q[i] = q[i+2]; q[i+2] = k;
			end
		end
		if ($urandom_range(1)) begin
			for (int i = 0; i < 4; i++) begin
				k = q[i]; q[i] = q[i+4]; q[i+4] = k;
			end
		end
		send_pair(q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7]);
	endtask

	initial begin
		out_stall = 1'b0;
		wait (arst_n);
		for (int rx_cycle = 0; ; rx_cycle++) begin
			@(posedge clk);
			if (rx_cycle >= 400 && rx_cycle < 480) begin
				out_stall <= 1'b1;
			end else if (rx_cycle >= 800 && rx_cycle < 1100) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < IDLE_PERCENT);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("segment_intersection_test: mismatch");
		$finish;
	end

	initial begin
		in_valid = 1'b0;
		ax = '0;
		ay = '0;
		bx = '0;
		by = '0;
		cx = '0;
		cy = '0;
		dx = '0;
		dy = '0;
		tx_calm = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pair(-10, 0, 10, 0, 0, -10, 0, 10);
		send_pair(10, 0, -10, 0, 0, 10, 0, -10);
		send_pair(0, 0, 10, 0, 0, 1, 10, 1);
		send_pair(0, 0, 10, 0, 5, 0, 15, 0);
		send_pair(0, 0, 10, 0, 11, 0, 20, 0);
		send_pair(0, 0, 10, 10, 10, 10, 20, 0);
		send_pair(0, 0, 10, 0, 5, 0, 5, 7);
		send_pair(0, 0, 10, 0, 11, -1, 11, 1);
		send_pair(3, -5, 3, 5, 3, 0, 9, 9);
		send_pair(3, -5, 3, 5, 3, 6, 3, 9);
		send_pair(3, 5, 3, -5, 3, -7, 3, 0);
		send_pair(0, 0, 0, 10, 0, 10, 5, 20);
		send_pair(4, 4, 4, 4, 0, 0, 8, 8);
		send_pair(9, 9, 9, 9, 0, 0, 8, 8);
		send_pair(0, 0, 10, 0, 5, 0, 5, 0);
		send_pair(7, -7, 7, -7, 7, -7, 7, -7);
		send_pair(1, 1, 1, 1, 2, 2, 2, 2);
		send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		send_pair(-32768, 32767, 32767, 32767, 0, 32767, 32767, 32767);
		send_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
		send_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		send_pair(-1, -1, 1, 1, -1, 1, 1, -1);

		// sender pauses until the pipeline is empty
		wait_drained();

		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			tx_calm = (n >= 500 && n < 650);
			if (n == 300) begin
				wait_drained();
			end
			send_random_pair();
		end

		wait_drained();
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("segment_intersection_test: match");
		end else begin
			$display("segment_intersection_test: mismatch");
		end
		$finish;
	end

endmodule
